@@ design/h13bs_pkg.sv @@
// ----------------------------------------------------------------------------
// h13bs_pkg
// Types, constants and the codeword function shared by the hamming-13
// byte-stuffing encoder.
// ----------------------------------------------------------------------------
package h13bs_pkg;

    localparam int unsigned CW_W        = 13;
    localparam int unsigned ACC_W       = 20;
    localparam logic [3:0]  MAX_RESULTS = 4'd15;

    localparam logic [1:0] CFG_ESCAPE = 2'd0;
    localparam logic [1:0] CFG_HEADER = 2'd1;
    localparam logic [1:0] CFG_FOOTER = 2'd2;

    localparam logic [7:0] ESCAPE_RESET = 8'h5c;
    localparam logic [7:0] HEADER_RESET = 8'hf8;
    localparam logic [7:0] FOOTER_RESET = 8'hc6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_item;
        logic       item_last;
    } q_entry_t;

    typedef struct packed {
        logic [7:0] escape_byte;
        logic [7:0] header_byte;
        logic [7:0] footer_byte;
    } cfg_t;

    // stream bytes still owed by a final item, indexed by codewords already in the group
    localparam logic [3:0] FLUSH_BYTES [8] = '{
        4'd13, 4'd12, 4'd10, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2
    };

    function automatic logic [CW_W-1:0] encode13(input logic [7:0] d);
        logic [CW_W-1:0] b;
        b     = '0;
        b[2]  = d[0];
        b[4]  = d[1];
        b[5]  = d[2];
        b[6]  = d[3];
        b[8]  = d[4];
        b[9]  = d[5];
        b[10] = d[6];
        b[11] = d[7];
        b[12] = ^d;
        b[0]  = b[2] ^ b[4] ^ b[6] ^ b[8] ^ b[10] ^ b[12];
        b[1]  = b[2] ^ b[5] ^ b[6] ^ b[9] ^ b[10];
        b[3]  = b[4] ^ b[5] ^ b[6] ^ b[11] ^ b[12];
        b[7]  = b[8] ^ b[9] ^ b[10] ^ b[11] ^ b[12];
        return b;
    endfunction

endpackage

@@ design/h13bs_front.sv @@
// ----------------------------------------------------------------------------
// h13bs_front
// Accepts input items, builds the codeword, appends it to the bit stream and
// pushes the completed stream bytes into the queue, zero padding on a final item.
// ----------------------------------------------------------------------------
module h13bs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  h13bs_pkg::in_item_t s_data,
    input  logic                q_full,
    output logic                q_push,
    output h13bs_pkg::q_entry_t q_wdata
);
    import h13bs_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [3:0]       left_reg, left_next;
    logic             item_last_reg, item_last_next;
    logic [6:0]       pend_bits_reg, pend_bits_next;
    logic [2:0]       pend_cnt_reg, pend_cnt_next;
    logic [2:0]       phase_reg, phase_next;

    logic [ACC_W-1:0] acc_new;
    logic [4:0]       sum_cnt;
    logic             two_bytes;
    logic             accept;

    assign q_push  = (left_reg != 4'd0) && !q_full;
    assign s_ready = (left_reg == 4'd0) || ((left_reg == 4'd1) && q_push);
    assign accept  = s_valid && s_ready;

    assign q_wdata.stream_byte = acc_reg[7:0];
    assign q_wdata.end_of_item = (left_reg == 4'd1);
    assign q_wdata.item_last   = item_last_reg;

    always_comb begin
        acc_new   = ({{(ACC_W-CW_W){1'b0}}, encode13(s_data.data_byte)} << pend_cnt_reg)
                  | {{(ACC_W-7){1'b0}}, pend_bits_reg};
        sum_cnt   = {2'b00, pend_cnt_reg} + 5'd13;
        two_bytes = sum_cnt[4];

        acc_next       = acc_reg;
        left_next      = left_reg;
        item_last_next = item_last_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        phase_next     = phase_reg;

        if (accept) begin
            acc_next       = acc_new;
            item_last_next = s_data.last_byte;
            if (s_data.last_byte) begin
                left_next      = FLUSH_BYTES[phase_reg];
                pend_bits_next = '0;
                pend_cnt_next  = '0;
                phase_next     = '0;
            end else begin
                left_next      = two_bytes ? 4'd2 : 4'd1;
                pend_bits_next = two_bytes ? {3'b000, acc_new[19:16]} : acc_new[14:8];
                pend_cnt_next  = sum_cnt[2:0];
                phase_next     = phase_reg + 3'd1;
            end
        end else if (q_push) begin
            acc_next  = acc_reg >> 8;
            left_next = left_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg      <= '0;
            item_last_reg <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            phase_reg     <= '0;
        end else begin
            left_reg      <= left_next;
            item_last_reg <= item_last_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

endmodule

@@ design/h13bs_queue.sv @@
// ----------------------------------------------------------------------------
// h13bs_queue
// Short queue of stream bytes between the front and the back.
// ----------------------------------------------------------------------------
module h13bs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  h13bs_pkg::q_entry_t wdata,
    output logic                full,
    input  logic                pop,
    output h13bs_pkg::q_entry_t rdata,
    output logic                empty
);
    import h13bs_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t         store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/h13bs_back.sv @@
// ----------------------------------------------------------------------------
// h13bs_back
// Takes stream bytes from the queue, inserts escapes before special values,
// caps the results of one item and drives the registered output channel.
// ----------------------------------------------------------------------------
module h13bs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  h13bs_pkg::cfg_t      cfg,
    input  h13bs_pkg::q_entry_t  q_rdata,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output h13bs_pkg::out_item_t m_data
);
    import h13bs_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic [3:0] res_cnt_reg, res_cnt_next;
    logic      esc_done_reg, esc_done_next;
    logic      drop_reg, drop_next;

    logic out_free, special, cap;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign special  = (q_rdata.stream_byte == cfg.escape_byte)
                   || (q_rdata.stream_byte == cfg.header_byte)
                   || (q_rdata.stream_byte == cfg.footer_byte);
    assign cap      = (res_cnt_reg == MAX_RESULTS - 4'd1);

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        res_cnt_next  = res_cnt_reg;
        esc_done_next = esc_done_reg;
        drop_next     = drop_reg;
        q_pop         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (!q_empty) begin
            if (drop_reg) begin
                // results past the cap are discarded up to the end of the item
                q_pop = 1'b1;
                if (q_rdata.end_of_item) begin
                    drop_next = 1'b0;
                end
            end else if (out_free) begin
                m_valid_next = 1'b1;
                if (special && !esc_done_reg) begin
                    m_data_next.out_byte = cfg.escape_byte;
                    m_data_next.out_last = q_rdata.item_last && cap;
                    if (cap) begin
                        q_pop         = 1'b1;
                        esc_done_next = 1'b0;
                        res_cnt_next  = '0;
                        drop_next     = !q_rdata.end_of_item;
                    end else begin
                        esc_done_next = 1'b1;
                        res_cnt_next  = res_cnt_reg + 4'd1;
                    end
                end else begin
                    m_data_next.out_byte = q_rdata.stream_byte;
                    m_data_next.out_last = q_rdata.item_last && (q_rdata.end_of_item || cap);
                    q_pop         = 1'b1;
                    esc_done_next = 1'b0;
                    if (q_rdata.end_of_item || cap) begin
                        res_cnt_next = '0;
                        drop_next    = !q_rdata.end_of_item;
                    end else begin
                        res_cnt_next = res_cnt_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            res_cnt_reg  <= '0;
            esc_done_reg <= 1'b0;
            drop_reg     <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            res_cnt_reg  <= res_cnt_next;
            esc_done_reg <= esc_done_next;
            drop_reg     <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

@@ design/hamming13_byte_stuff_encoder.sv @@
// ----------------------------------------------------------------------------
// hamming13_byte_stuff_encoder
// Hamming-13 encoder with byte stuffing of escape, header and footer values.
//
// s_* takes one payload byte per item (valid/ready); last_byte closes the
// stream, which is then zero padded to a whole group of eight codewords and
// flushed. m_* gives one output byte per item; out_last marks the final byte
// caused by a closing input. Results beyond fifteen for one input are dropped.
// The user must write escape, header and footer values through the cfg_* port,
// one per cycle, only while the block is idle; the block does not enforce this.
// An accepted input passes through the front accumulator, the queue and the
// output register. Throughput: one output byte per cycle while the receiver
// is ready and the queue holds bytes, set by the output register; an ordinary
// input yields one or two stream bytes (up to four with escapes). A closing
// input yields up to thirteen stream bytes. The front issues one stream byte
// per cycle, unless the FIFO_DEPTH entry queue is full, and takes the next
// input in the cycle it issues the last byte. A stalled receiver holds the
// output register, fills the queue, then drops s_ready. Reset clears the bit
// stream, the group position and the queue, and restores the register reset values.
// ----------------------------------------------------------------------------
module hamming13_byte_stuff_encoder #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  h13bs_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output h13bs_pkg::out_item_t m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata
);
    import h13bs_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    q_entry_t q_wdata, q_rdata;
    logic     q_push, q_pop, q_full, q_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_ESCAPE: cfg_next.escape_byte = cfg_wdata;
                CFG_HEADER: cfg_next.header_byte = cfg_wdata;
                CFG_FOOTER: cfg_next.footer_byte = cfg_wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_byte <= ESCAPE_RESET;
            cfg_reg.header_byte <= HEADER_RESET;
            cfg_reg.footer_byte <= FOOTER_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    h13bs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    h13bs_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    h13bs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_rdata (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
